FILE: hw/rtl/rbtx_pkg.sv
package rbtx_pkg;

  // Store geometry
  localparam int unsigned BufDepth = 256;
  localparam int unsigned IdxW     = $clog2(BufDepth);
  localparam int unsigned LenW     = $clog2(BufDepth + 1);

  // Item kinds
  localparam logic [1:0] KindWrite    = 2'd0;
  localparam logic [1:0] KindEndCall  = 2'd1;
  localparam logic [1:0] KindComplete = 2'd2;
  localparam logic [1:0] KindRead     = 2'd3;

  // Dispatch outcome handed from the pointer logic to the top level
  typedef struct packed {
    logic            launch;
    logic [IdxW-1:0] start;
    logic [LenW-1:0] length;
    logic            busy;
  } disp_t;

endpackage

FILE: hw/rtl/rbtx_store.sv
module rbtx_store (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [rbtx_pkg::IdxW-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  input  logic                     rd_en_i,
  input  logic [rbtx_pkg::IdxW-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);

  logic [7:0] mem_q [rbtx_pkg::BufDepth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: hw/rtl/rbtx_ctrl.sv
module rbtx_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [1:0]                kind_i,
  output logic [rbtx_pkg::IdxW-1:0] fill_o,
  output rbtx_pkg::disp_t           disp_o
);

  logic [rbtx_pkg::IdxW-1:0] fill_q, fill_d;
  logic [rbtx_pkg::IdxW-1:0] send_q, send_d;
  logic                      busy_q, busy_d;

  localparam logic [rbtx_pkg::LenW-1:0] DepthLen = rbtx_pkg::LenW'(rbtx_pkg::BufDepth);
  localparam logic [rbtx_pkg::IdxW-1:0] LastIdx  = rbtx_pkg::IdxW'(rbtx_pkg::BufDepth - 1);

  logic do_disp;

  // Pointer update and chunk dispatch
  always_comb begin
    fill_d = fill_q;
    send_d = send_q;
    busy_d = busy_q;
    disp_o = '0;
    do_disp = 1'b0;

    case (kind_i)
      rbtx_pkg::KindWrite: begin
        fill_d = (fill_q == LastIdx) ? '0 : fill_q + 1'b1;
      end
      rbtx_pkg::KindEndCall:  do_disp = !busy_q;
      rbtx_pkg::KindComplete: do_disp = 1'b1;
      default: ;
    endcase

    if (do_disp) begin
      if (send_q < fill_q) begin
        disp_o.launch = 1'b1;
        disp_o.start  = send_q;
        disp_o.length = {1'b0, fill_q} - {1'b0, send_q};
        send_d        = fill_q;
        busy_d        = 1'b1;
      end else if (send_q > fill_q) begin
        disp_o.launch = 1'b1;
        disp_o.start  = send_q;
        disp_o.length = DepthLen - {1'b0, send_q};
        send_d        = '0;
        busy_d        = 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
    disp_o.busy = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      send_q <= '0;
      busy_q <= 1'b0;
    end else if (accept_i) begin
      fill_q <= fill_d;
      send_q <= send_d;
      busy_q <= busy_d;
    end
  end

  assign fill_o = fill_q;

endmodule

FILE: hw/rtl/ring_buffer_tx_chunk_dispatch.sv
// Transmit ring buffer with chunk dispatch.
// The result strobe is registered and follows the accepting edge.
// Throughput: one item per cycle and busy stays low; an item needs one pointer
// update and at most one store access, and results are never held off.
// Reset clears the fill and send indexes, the transfer-busy flag and the
// result strobe; store contents stay undefined until written.
module ring_buffer_tx_chunk_dispatch (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind_i,
  input  logic [7:0]                data_byte_i,
  input  logic [7:0]                read_index_i,
  output logic                      result_valid_o,
  output logic                      launch_o,
  output logic [7:0]                chunk_start_o,
  output logic [8:0]                chunk_length_o,
  output logic                      busy_flag_o,
  output logic [7:0]                read_data_o
);

  logic                      accept;
  logic [rbtx_pkg::IdxW-1:0] fill;
  rbtx_pkg::disp_t           disp;
  rbtx_pkg::disp_t           disp_q;
  logic                      is_read_q;
  logic                      valid_q;
  logic [7:0]                rd_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rbtx_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (kind_i),
    .fill_o   (fill),
    .disp_o   (disp)
  );

  rbtx_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept && (kind_i == rbtx_pkg::KindWrite)),
    .wr_addr_i (fill),
    .wr_data_i (data_byte_i),
    .rd_en_i   (accept && (kind_i == rbtx_pkg::KindRead)),
    .rd_addr_i (read_index_i[rbtx_pkg::IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      disp_q    <= disp;
      is_read_q <= (kind_i == rbtx_pkg::KindRead);
    end
  end

  assign result_valid_o = valid_q;
  assign launch_o       = disp_q.launch;
  assign chunk_start_o  = 8'(disp_q.start);
  assign chunk_length_o = 9'(disp_q.length);
  assign busy_flag_o    = disp_q.busy;
  assign read_data_o    = is_read_q ? rd_data : 8'd0;

endmodule

FILE: hw/rtl/rbtx_checker.sv
module rbtx_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       busy,
  input  logic       result_valid_o,
  input  logic       launch_o,
  input  logic [7:0] chunk_start_o,
  input  logic [8:0] chunk_length_o,
  input  logic       busy_flag_o
);

  // Every transfer in gives exactly one result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("missing result after transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !result_valid_o)
    else $error("result without transfer");

  // A launch always leaves a transfer outstanding and moves at least one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && launch_o) |-> (busy_flag_o && (chunk_length_o != 9'd0)))
    else $error("launch without busy or with empty chunk");

  // No launch means empty chunk fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !launch_o) |-> ((chunk_start_o == 8'd0) && (chunk_length_o == 9'd0)))
    else $error("chunk fields set without launch");

endmodule

bind ring_buffer_tx_chunk_dispatch rbtx_checker u_rbtx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .launch_o       (launch_o),
  .chunk_start_o  (chunk_start_o),
  .chunk_length_o (chunk_length_o),
  .busy_flag_o    (busy_flag_o)
);
